[rtl/stkps_pkg.sv]
// Shared types, widths and codes for the streaming top-K penalized sum block.
package stkps_pkg;

	localparam int HEAP_DEPTH_DEF = 64;
	localparam int SAMPLE_W = 32;
	localparam int VAL_W = 31;
	localparam int SUM_W = 40;
	localparam int IDX_W = 31;
	localparam int PEN_W = 31;
	localparam int LIMIT_W = 7;
	localparam int PROD_W = IDX_W + PEN_W;
	localparam int CFG_W = 31;

	localparam logic [LIMIT_W-1:0] LIMIT_RST = 7'd1;
	localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};

	typedef enum logic [0:0] {
		CFG_KEEP_LIMIT = 1'b0,
		CFG_STEP_PENALTY = 1'b1
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_ROOT_CMP,
		S_UP_CHK,
		S_UP_CMP,
		S_DN_CHK,
		S_DN_CMP,
		S_MUL,
		S_SCORE,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic decide;
		logic root_cmp;
		logic up_chk;
		logic up_cmp;
		logic dn_chk;
		logic dn_cmp;
		logic mul;
		logic score;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic do_insert;
		logic do_check;
		logic root_take;
		logic up_top;
		logic up_stop;
		logic dn_leaf;
		logic dn_stop;
	} dp_sts_t;

endpackage

[rtl/stkps_in_if.sv]
// Input channel: one sample word with its restart flag.
interface stkps_in_if;
	logic valid;
	logic ready;
	logic signed [31:0] sample;
	logic restart;

	modport source (output valid, output sample, output restart, input ready);
	modport sink (input valid, input sample, input restart, output ready);
endinterface

[rtl/stkps_out_if.sv]
// Output channel: running sum and best score word.
interface stkps_out_if;
	logic valid;
	logic ready;
	logic [39:0] running_sum;
	logic [39:0] best_score;

	modport source (output valid, output running_sum, output best_score, input ready);
	modport sink (input valid, input running_sum, input best_score, output ready);
endinterface

[rtl/stkps_ctrl.sv]
// Controller state machine: sequences load, heap sift, score and output load.
module stkps_ctrl
	import stkps_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			out_valid_q <= cmd.out_load || (out_valid_q && !out_ready);
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				if (sts.do_insert) state_d = S_UP_CHK;
				else if (sts.do_check) state_d = S_ROOT_CMP;
				else state_d = S_MUL;
			end
			S_ROOT_CMP: begin
				cmd.root_cmp = 1'b1;
				state_d = sts.root_take ? S_DN_CHK : S_MUL;
			end
			S_UP_CHK: begin
				cmd.up_chk = 1'b1;
				state_d = sts.up_top ? S_MUL : S_UP_CMP;
			end
			S_UP_CMP: begin
				cmd.up_cmp = 1'b1;
				state_d = sts.up_stop ? S_MUL : S_UP_CHK;
			end
			S_DN_CHK: begin
				cmd.dn_chk = 1'b1;
				state_d = sts.dn_leaf ? S_MUL : S_DN_CMP;
			end
			S_DN_CMP: begin
				cmd.dn_cmp = 1'b1;
				state_d = sts.dn_stop ? S_MUL : S_DN_CHK;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_SCORE;
			end
			S_SCORE: begin
				cmd.score = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				// hold the result until the output register is free
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

`ifndef ASSERT_OFF
	a_accept_to_decide: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_DECIDE))
		else $error("accepted word did not advance to decide");

	a_load_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (state_q == S_DONE && out_free))
		else $error("output loaded while slot busy");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result word dropped while stalled");
`endif

endmodule

[rtl/stkps_dp.sv]
// Datapath: config registers, heap memory, sum, index, penalty score, output register.
module stkps_dp
	import stkps_pkg::*;
#(
	parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  cfg_idx_t               cfg_index,
	input  logic [CFG_W-1:0]       cfg_data,
	input  logic [SAMPLE_W-1:0]    sample,
	input  logic                   restart,
	input  dp_cmd_t                cmd,
	output dp_sts_t                sts,
	output logic [SUM_W-1:0]       running_sum,
	output logic [SUM_W-1:0]       best_score
);

	localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
	localparam int CNT_W = $clog2(HEAP_DEPTH + 1);
	localparam int CW = (LIMIT_W > CNT_W) ? LIMIT_W : CNT_W;
	localparam int XW = AW + 2;
	localparam logic [CW-1:0] DEPTH_C = CW'(HEAP_DEPTH);

	logic [LIMIT_W-1:0] keep_limit_q;
	logic [PEN_W-1:0]   pen_q;
	logic [CNT_W-1:0]   count_q;
	logic [SUM_W-1:0]   sum_q;
	logic [IDX_W-1:0]   idx_q;
	logic [SUM_W-1:0]   best_q;

	logic [SAMPLE_W-1:0] sample_q;
	logic [VAL_W-1:0]    val_q;
	logic [AW-1:0]       pos_q;
	logic [PROD_W-1:0]   prod_q;
	logic [SUM_W-1:0]    running_sum_q;
	logic [SUM_W-1:0]    best_score_q;

	logic [VAL_W-1:0] heap_q [HEAP_DEPTH];
	logic [VAL_W-1:0] rd0_q;
	logic [VAL_W-1:0] rd1_q;

	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [VAL_W-1:0]  mem_wdata;
	logic              rd_en;
	logic [AW-1:0]     rd0_addr;
	logic [AW-1:0]     rd1_addr;

	logic [CW-1:0]     limit_c;
	logic [CW-1:0]     count_c;
	logic              positive;
	logic [AW-1:0]     parent;
	logic [XW-1:0]     left_x;
	logic [XW-1:0]     right_x;
	logic [XW-1:0]     count_x;
	logic              right_ok;
	logic              pick_right;
	logic [VAL_W-1:0]  small_val;
	logic [AW-1:0]     small_addr;
	logic [PROD_W-1:0] sum_x;
	logic [SUM_W-1:0]  score;

	assign limit_c = (CW'(keep_limit_q) > DEPTH_C) ? DEPTH_C : CW'(keep_limit_q);
	assign count_c = CW'(count_q);
	assign positive = (sample_q != '0) && !sample_q[SAMPLE_W-1];
	assign parent = AW'((pos_q - 1'b1) >> 1);
	assign left_x = {1'b0, pos_q, 1'b1};
	assign right_x = left_x + 1'b1;
	assign count_x = XW'(count_q);
	assign right_ok = right_x < count_x;
	assign pick_right = right_ok && (rd1_q < rd0_q);
	assign small_val = pick_right ? rd1_q : rd0_q;
	assign small_addr = pick_right ? right_x[AW-1:0] : left_x[AW-1:0];
	assign sum_x = PROD_W'(sum_q);
	assign score = SUM_W'(sum_x - prod_q);

	always_comb begin
		sts.do_insert = positive && (count_c < limit_c);
		sts.do_check = positive && (count_c == limit_c) && (limit_c != '0);
		sts.root_take = val_q > rd0_q;
		sts.up_top = pos_q == '0;
		sts.up_stop = val_q >= rd0_q;
		sts.dn_leaf = left_x >= count_x;
		sts.dn_stop = val_q <= small_val;
	end

	// heap write port: the carried value fills the hole once its place is found
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = val_q;
		if (cmd.up_chk && sts.up_top) begin
			mem_we = 1'b1;
		end else if (cmd.up_cmp) begin
			mem_we = 1'b1;
			mem_wdata = sts.up_stop ? val_q : rd0_q;
		end else if (cmd.dn_chk && sts.dn_leaf) begin
			mem_we = 1'b1;
		end else if (cmd.dn_cmp) begin
			mem_we = 1'b1;
			mem_wdata = sts.dn_stop ? val_q : small_val;
		end
	end

	always_comb begin
		rd_en = 1'b0;
		rd0_addr = '0;
		rd1_addr = '0;
		if (cmd.decide && sts.do_check) begin
			rd_en = 1'b1;
		end else if (cmd.up_chk && !sts.up_top) begin
			rd_en = 1'b1;
			rd0_addr = parent;
		end else if (cmd.dn_chk && !sts.dn_leaf) begin
			rd_en = 1'b1;
			rd0_addr = left_x[AW-1:0];
			rd1_addr = right_ok ? right_x[AW-1:0] : left_x[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) heap_q[mem_waddr] <= mem_wdata;
		if (rd_en) begin
			rd0_q <= heap_q[rd0_addr];
			rd1_q <= heap_q[rd1_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_limit_q <= LIMIT_RST;
			pen_q <= '0;
			count_q <= '0;
			sum_q <= '0;
			idx_q <= '0;
			best_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_KEEP_LIMIT:   keep_limit_q <= cfg_data[LIMIT_W-1:0];
					CFG_STEP_PENALTY: pen_q <= cfg_data[PEN_W-1:0];
				endcase
			end
			if (cmd.load) begin
				if (restart) begin
					count_q <= '0;
					sum_q <= '0;
					best_q <= '0;
					idx_q <= IDX_W'(1);
				end else if (idx_q != IDX_MAX) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (cmd.decide && sts.do_insert) begin
				count_q <= count_q + 1'b1;
				sum_q <= sum_q + SUM_W'(sample_q[VAL_W-1:0]);
			end
			if (cmd.root_cmp && sts.root_take) begin
				sum_q <= sum_q - SUM_W'(rd0_q) + SUM_W'(val_q);
			end
			if (cmd.score && (sum_x > prod_q) && (score > best_q)) begin
				best_q <= score;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) sample_q <= sample;
		if (cmd.decide) begin
			val_q <= sample_q[VAL_W-1:0];
			pos_q <= count_q[AW-1:0];
		end
		if (cmd.root_cmp) pos_q <= '0;
		if (cmd.up_cmp && !sts.up_stop) pos_q <= parent;
		if (cmd.dn_cmp && !sts.dn_stop) pos_q <= small_addr;
		if (cmd.mul) prod_q <= PROD_W'(idx_q) * PROD_W'(pen_q);
		if (cmd.out_load) begin
			running_sum_q <= sum_q;
			best_score_q <= best_q;
		end
	end

	assign running_sum = running_sum_q;
	assign best_score = best_score_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(count_q) <= DEPTH_C)
		else $error("kept count above heap depth");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.decide && sts.do_insert) |=> (count_q == $past(count_q) + 1'b1))
		else $error("insert did not grow kept count");

	a_best_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load && restart) |=> (best_q >= $past(best_q)))
		else $error("best score dropped without restart");
`endif

endmodule

[rtl/streaming_top_k_penalized_sum.sv]
// Streaming top-K penalized sum: top level joining controller and datapath.
// After accept the word is decided; a sift up, or a root compare and perhaps a sift down (a check
// and a compare state per heap level), may run before the multiply, score and output load states.
// One word at a time: a new word is taken the cycle after the result loads, and the result
// waits in the done state while the output stalls.
// Reset: arst_n clears config (keep_limit 1, step_penalty 0), count, sum, index, best.
module streaming_top_k_penalized_sum
	import stkps_pkg::*;
#(
	parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  cfg_idx_t         cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	stkps_in_if.sink         in_ch,
	stkps_out_if.source      out_ch
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	stkps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	stkps_dp #(
		.HEAP_DEPTH (HEAP_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.sample      (in_ch.sample),
		.restart     (in_ch.restart),
		.cmd         (cmd),
		.sts         (sts),
		.running_sum (out_ch.running_sum),
		.best_score  (out_ch.best_score)
	);

endmodule

[bench/streaming_top_k_penalized_sum_tb.sv]
// Self-checking bench for the streaming top-K penalized sum block: directed table, then random phases.
module streaming_top_k_penalized_sum_tb;
	import stkps_pkg::*;

	localparam int DEPTH = HEAP_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 500000;
	localparam int TAIL_CYCLES = 40;
	localparam int WORDS_PER_PHASE = 150;
	localparam int PHASES = 8;

	typedef enum logic [1:0] {
		ST_WORD,
		ST_SET_LIMIT,
		ST_SET_PENALTY
	} step_kind_t;

	typedef struct {
		step_kind_t kind;
		logic [31:0] value;
		logic restart;
		bit fixed;
		logic [SUM_W-1:0] sum;
		logic [SUM_W-1:0] best;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	cfg_idx_t cfg_index = CFG_KEEP_LIMIT;
	logic [CFG_W-1:0] cfg_data = '0;

	stkps_in_if in_ch();
	stkps_out_if out_ch();

	streaming_top_k_penalized_sum #(.HEAP_DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// mirror of the block's registers and selection
	logic [LIMIT_W-1:0] lim_cfg = LIMIT_RST;
	logic [PEN_W-1:0] pen_cfg = '0;
	logic [VAL_W-1:0] kept[$];
	logic [SUM_W-1:0] sum_m = '0;
	logic [IDX_W-1:0] idx_m = '0;
	logic [SUM_W-1:0] best_m = '0;

	logic [SUM_W-1:0] due_sums[$];
	logic [SUM_W-1:0] due_bests[$];

	int errors = 0;
	int cycles = 0;
	int stall_left = 0;
	bit calm = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void advance_selection(input logic [31:0] raw, input logic rst,
			output logic [SUM_W-1:0] sum_out, output logic [SUM_W-1:0] best_out);
		int lim;
		int low_pos;
		bit positive;
		logic [PROD_W-1:0] cost;
		lim = (lim_cfg > DEPTH) ? DEPTH : int'(lim_cfg);
		positive = (raw != 32'd0) && !raw[31];
		if (rst) begin
			kept.delete();
			sum_m = '0;
			idx_m = '0;
			best_m = '0;
		end
		if (idx_m != IDX_MAX)
			idx_m = idx_m + 1'b1;
		if (kept.size() < lim) begin
			if (positive) begin
				kept.push_back(raw[VAL_W-1:0]);
				sum_m = sum_m + SUM_W'(raw[VAL_W-1:0]);
			end
		end else if (kept.size() == lim && lim > 0 && positive) begin
			low_pos = 0;
			for (int i = 1; i < kept.size(); i++)
				if (kept[i] < kept[low_pos])
					low_pos = i;
			// a tie with the smallest kept value leaves the set alone
			if (raw[VAL_W-1:0] > kept[low_pos]) begin
				sum_m = sum_m - SUM_W'(kept[low_pos]) + SUM_W'(raw[VAL_W-1:0]);
				kept[low_pos] = raw[VAL_W-1:0];
			end
		end
		cost = PROD_W'(idx_m) * PROD_W'(pen_cfg);
		if (PROD_W'(sum_m) > cost && sum_m - cost[SUM_W-1:0] > best_m)
			best_m = sum_m - cost[SUM_W-1:0];
		sum_out = sum_m;
		best_out = best_m;
	endfunction

	function automatic logic [31:0] draw_sample();
		logic [31:0] v;
		case ($urandom_range(0, 9))
			0, 1, 2: v = $urandom_range(1, 64);
			3, 4: v = $urandom;
			5, 6: v = 32'h7FFF_FFFF - $urandom_range(0, 1000);
			7: v = {1'b0, 31'($urandom)};
			8: v = 32'h8000_0000 + $urandom_range(0, 3);
			default: v = $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
		endcase
		return v;
	endfunction

	// called at a falling edge; returns at a falling edge
	task automatic push_word(input logic [31:0] raw, input logic rst, input bit fixed,
			input logic [SUM_W-1:0] fsum, input logic [SUM_W-1:0] fbest);
		logic [SUM_W-1:0] ps;
		logic [SUM_W-1:0] pb;
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.sample <= raw;
		in_ch.restart <= rst;
		do
			@(posedge clk);
		while (in_ch.ready !== 1'b1);
		advance_selection(raw, rst, ps, pb);
		due_sums.push_back(fixed ? fsum : ps);
		due_bests.push_back(fixed ? fbest : pb);
		@(negedge clk);
	endtask

	// write only with the block drained
	task automatic set_register(input cfg_idx_t which, input logic [CFG_W-1:0] value);
		in_ch.valid <= 1'b0;
		while (due_sums.size() != 0)
			@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= which;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (which == CFG_KEEP_LIMIT)
			lim_cfg = value[LIMIT_W-1:0];
		else
			pen_cfg = value[PEN_W-1:0];
	endtask

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ch.ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 3);
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		logic [SUM_W-1:0] es;
		logic [SUM_W-1:0] eb;
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end else if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (due_sums.size() == 0) begin
				$error("result word with nothing expected: running_sum %0d best_score %0d",
					out_ch.running_sum, out_ch.best_score);
				errors = errors + 1;
			end else begin
				es = due_sums.pop_front();
				eb = due_bests.pop_front();
				if (out_ch.running_sum !== es) begin
					$error("running_sum: expected %0d, got %0d", es, out_ch.running_sum);
					errors = errors + 1;
				end
				if (out_ch.best_score !== eb) begin
					$error("best_score: expected %0d, got %0d", eb, out_ch.best_score);
					errors = errors + 1;
				end
			end
		end
	end

	initial begin
		plan_row_t plan[$];
		logic [CFG_W-1:0] lims[PHASES];
		logic [CFG_W-1:0] pens[PHASES];
		in_ch.valid = 1'b0;
		in_ch.sample = '0;
		in_ch.restart = 1'b0;

		// reset settings: keep one, no penalty
		plan.push_back('{ST_WORD, 32'h0000_0000, 1'b0, 1'b1, 40'd0, 40'd0});
		plan.push_back('{ST_WORD, 32'h7FFF_FFFF, 1'b0, 1'b1, 40'd2147483647, 40'd2147483647});
		plan.push_back('{ST_WORD, 32'h8000_0000, 1'b0, 1'b1, 40'd2147483647, 40'd2147483647});
		plan.push_back('{ST_WORD, 32'hFFFF_FFFF, 1'b0, 1'b1, 40'd2147483647, 40'd2147483647});
		plan.push_back('{ST_WORD, 32'h7FFF_FFFF, 1'b0, 1'b1, 40'd2147483647, 40'd2147483647});
		plan.push_back('{ST_WORD, 32'd1, 1'b1, 1'b1, 40'd1, 40'd1});
		plan.push_back('{ST_WORD, 32'd5, 1'b0, 1'b1, 40'd5, 40'd5});
		plan.push_back('{ST_WORD, 32'd3, 1'b0, 1'b1, 40'd5, 40'd5});
		// zero limit: nothing kept, sum holds
		plan.push_back('{ST_SET_LIMIT, 32'd0, 1'b0, 1'b0, 40'd0, 40'd0});
		plan.push_back('{ST_WORD, 32'd100, 1'b0, 1'b1, 40'd5, 40'd5});
		plan.push_back('{ST_WORD, 32'h7FFF_FFFF, 1'b1, 1'b1, 40'd0, 40'd0});
		// limit above depth, penalty at its maximum
		plan.push_back('{ST_SET_LIMIT, 32'd100, 1'b0, 1'b0, 40'd0, 40'd0});
		plan.push_back('{ST_SET_PENALTY, 32'h7FFF_FFFF, 1'b0, 1'b0, 40'd0, 40'd0});
		plan.push_back('{ST_WORD, 32'h7FFF_FFFF, 1'b1, 1'b1, 40'd2147483647, 40'd0});
		plan.push_back('{ST_WORD, 32'h4000_0000, 1'b0, 1'b0, 40'd0, 40'd0});
		plan.push_back('{ST_WORD, 32'h7FFF_FFFE, 1'b0, 1'b0, 40'd0, 40'd0});
		plan.push_back('{ST_WORD, 32'd1, 1'b0, 1'b0, 40'd0, 40'd0});
		// fill four, replace, then lower the limit below the count
		plan.push_back('{ST_SET_LIMIT, 32'd4, 1'b0, 1'b0, 40'd0, 40'd0});
		plan.push_back('{ST_SET_PENALTY, 32'd1, 1'b0, 1'b0, 40'd0, 40'd0});
		plan.push_back('{ST_WORD, 32'd10, 1'b1, 1'b0, 40'd0, 40'd0});
		plan.push_back('{ST_WORD, 32'd20, 1'b0, 1'b0, 40'd0, 40'd0});
		plan.push_back('{ST_WORD, 32'd30, 1'b0, 1'b0, 40'd0, 40'd0});
		plan.push_back('{ST_WORD, 32'd40, 1'b0, 1'b0, 40'd0, 40'd0});
		plan.push_back('{ST_WORD, 32'd50, 1'b0, 1'b0, 40'd0, 40'd0});
		plan.push_back('{ST_SET_LIMIT, 32'd2, 1'b0, 1'b0, 40'd0, 40'd0});
		plan.push_back('{ST_WORD, 32'd60, 1'b0, 1'b0, 40'd0, 40'd0});
		plan.push_back('{ST_WORD, 32'd70, 1'b0, 1'b0, 40'd0, 40'd0});
		plan.push_back('{ST_SET_LIMIT, 32'd64, 1'b0, 1'b0, 40'd0, 40'd0});
		plan.push_back('{ST_SET_PENALTY, 32'd0, 1'b0, 1'b0, 40'd0, 40'd0});
		plan.push_back('{ST_WORD, 32'h7FFF_FFFF, 1'b0, 1'b0, 40'd0, 40'd0});
		plan.push_back('{ST_WORD, 32'd1, 1'b0, 1'b0, 40'd0, 40'd0});

		// dropping from 64 to 3 without restart keeps the count above the limit
		lims[0] = 31'd1;   pens[0] = 31'd0;
		lims[1] = 31'd64;  pens[1] = 31'd1000;
		lims[2] = 31'd3;   pens[2] = 31'h7FFF_FFFF;
		lims[3] = 31'd0;   pens[3] = 31'd5;
		lims[4] = 31'd100; pens[4] = 31'($urandom_range(0, 1 << 24));
		lims[5] = 31'd2;   pens[5] = 31'd0;
		lims[6] = 31'($urandom_range(1, 64)); pens[6] = 31'($urandom);
		lims[7] = 31'd64;  pens[7] = 31'($urandom_range(0, 4096));

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			case (plan[i].kind)
				ST_SET_LIMIT: set_register(CFG_KEEP_LIMIT, plan[i].value[CFG_W-1:0]);
				ST_SET_PENALTY: set_register(CFG_STEP_PENALTY, plan[i].value[CFG_W-1:0]);
				default: push_word(plan[i].value, plan[i].restart, plan[i].fixed,
					plan[i].sum, plan[i].best);
			endcase
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			set_register(CFG_KEEP_LIMIT, lims[ph]);
			set_register(CFG_STEP_PENALTY, pens[ph]);
			calm = (ph == PHASES - 1);
			repeat (WORDS_PER_PHASE)
				push_word(draw_sample(), $urandom_range(0, 49) == 0, 1'b0, '0, '0);
		end

		in_ch.valid <= 1'b0;
		while (due_sums.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[filelist.f]
rtl/stkps_pkg.sv
rtl/stkps_in_if.sv
rtl/stkps_out_if.sv
rtl/stkps_ctrl.sv
rtl/stkps_dp.sv
rtl/streaming_top_k_penalized_sum.sv
bench/streaming_top_k_penalized_sum_tb.sv
